// File: hdl/periodic_task_scheduler_unit_defines.svh
// ---------------------------------------------------------------------------
// Periodic task scheduler assertion macros
// Checks sampled on the rising edge of clock, off while reset is high.
// ---------------------------------------------------------------------------
`ifndef PERIODIC_TASK_SCHEDULER_UNIT_DEFINES_SVH
`define PERIODIC_TASK_SCHEDULER_UNIT_DEFINES_SVH

// same-cycle implication
`define PTSU_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PTSU_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/ptsu_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Periodic task scheduler package
// Sizes, item codes, controller states and controller/datapath bundles.
// ---------------------------------------------------------------------------
package ptsu_pkg;

   localparam int SLOTS      = 12;
   localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int KIND_W     = 2;
   localparam int TAG_W      = 16;
   localparam int WORD_W     = 32;
   localparam int STATUS_W   = 2;
   localparam int SLOT_W     = 4;

   localparam logic [KIND_W-1:0] KIND_ADD  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TICK = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RUN  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_ADDED    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DUE      = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NONE_DUE = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_TICK,
      ST_RUN,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic capture;
      logic add_step;
      logic tick_step;
      logic run_step;
      logic flush_step;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
   } stat_type;

   // slot number as carried on the result port, modulo 16
   function automatic logic [SLOT_W-1:0] slot_field(input logic [SLOT_IDX_W-1:0] idx);
      logic [63:0] wide;
      wide = 64'(idx);
      return wide[SLOT_W-1:0];
   endfunction

endpackage

// File: hdl/periodic_task_scheduler_unit.sv
// Add: the item is captured, checked in the add state and its result registered; busy for one cycle.
// Tick: one slot per cycle through the table port while busy; no result.
// Run: each due item is held until the next due slot is found; the last item (or the none-due
//   item) is registered from the flush state that follows the scan.
// Synchronous reset empties the table and sets the tick amount to one.
// Results are strobed for one cycle each; the receiver cannot stall.
`timescale 1ns / 1ps
`include "periodic_task_scheduler_unit_defines.svh"
// ---------------------------------------------------------------------------
// Periodic task scheduler unit
// Slot table of periodic tasks with add, tick and run-pending items.
// ---------------------------------------------------------------------------
module periodic_task_scheduler_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [ptsu_pkg::KIND_W-1:0]   req_kind,
   input  logic [ptsu_pkg::TAG_W-1:0]    req_task_tag,
   input  logic [ptsu_pkg::WORD_W-1:0]   req_task_argument,
   input  logic [ptsu_pkg::WORD_W-1:0]   req_period,
   input  logic                          csr_wr_en,
   input  logic [ptsu_pkg::WORD_W-1:0]   csr_wr_data,
   output logic                          rsp_valid,
   output logic [ptsu_pkg::STATUS_W-1:0] rsp_status,
   output logic [ptsu_pkg::SLOT_W-1:0]   rsp_slot,
   output logic [ptsu_pkg::TAG_W-1:0]    rsp_due_tag,
   output logic [ptsu_pkg::WORD_W-1:0]   rsp_due_argument,
   output logic                          rsp_last
);

   ptsu_pkg::cmd_type  cmd;
   ptsu_pkg::stat_type stat;
   logic               req_accept;
   logic               add_accept;
   logic               tick_accept;
   logic               add_result;
   logic               none_due_result;
   logic               none_due_clean;

   assign req_accept      = start && !busy;
   assign add_accept      = req_accept && (req_kind == ptsu_pkg::KIND_ADD);
   assign tick_accept     = req_accept && (req_kind == ptsu_pkg::KIND_TICK);
   assign add_result      = rsp_valid && ((rsp_status == ptsu_pkg::STATUS_ADDED) ||
                                          (rsp_status == ptsu_pkg::STATUS_REJECTED));
   assign none_due_result = rsp_valid && (rsp_status == ptsu_pkg::STATUS_NONE_DUE);
   assign none_due_clean  = rsp_last && (rsp_slot == '0) && (rsp_due_tag == '0);

   ptsu_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_kind),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   ptsu_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_task_tag      (req_task_tag),
      .req_task_argument (req_task_argument),
      .req_period        (req_period),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_slot          (rsp_slot),
      .rsp_due_tag       (rsp_due_tag),
      .rsp_due_argument  (rsp_due_argument),
      .rsp_last          (rsp_last)
   );

   `PTSU_ASSERT_NXT(a_add_holds_busy, add_accept, busy, "add item did not hold busy")
   `PTSU_ASSERT_NXT(a_tick_silent, tick_accept, !rsp_valid, "result right after tick item")
   `PTSU_ASSERT_IMP(a_add_last, add_result, rsp_last, "add result without last")
   `PTSU_ASSERT_IMP(a_none_due_clean, none_due_result, none_due_clean, "malformed none-due item")

endmodule

// File: hdl/ptsu_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Periodic task scheduler controller
// Sequences add, tick scan, run scan and run flush; drives busy.
// ---------------------------------------------------------------------------
module ptsu_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ptsu_pkg::KIND_W-1:0] req_kind,
   input  ptsu_pkg::stat_type          stat,
   output ptsu_pkg::cmd_type           cmd,
   output logic                        busy
);

   ptsu_pkg::state_type state_ff;
   ptsu_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptsu_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptsu_pkg::ST_IDLE: begin
            if (start) begin
               unique case (req_kind)
                  ptsu_pkg::KIND_ADD:  state_in = ptsu_pkg::ST_ADD;
                  ptsu_pkg::KIND_TICK: state_in = ptsu_pkg::ST_TICK;
                  ptsu_pkg::KIND_RUN:  state_in = ptsu_pkg::ST_RUN;
                  default:             state_in = ptsu_pkg::ST_IDLE;
               endcase
            end
         end
         ptsu_pkg::ST_ADD:   state_in = ptsu_pkg::ST_IDLE;
         ptsu_pkg::ST_TICK: begin
            if (stat.scan_last) state_in = ptsu_pkg::ST_IDLE;
         end
         ptsu_pkg::ST_RUN: begin
            if (stat.scan_last) state_in = ptsu_pkg::ST_FLUSH;
         end
         ptsu_pkg::ST_FLUSH: state_in = ptsu_pkg::ST_IDLE;
         default:            state_in = ptsu_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.capture    = (state_ff == ptsu_pkg::ST_IDLE) && start;
      cmd.add_step   = (state_ff == ptsu_pkg::ST_ADD);
      cmd.tick_step  = (state_ff == ptsu_pkg::ST_TICK);
      cmd.run_step   = (state_ff == ptsu_pkg::ST_RUN);
      cmd.flush_step = (state_ff == ptsu_pkg::ST_FLUSH);
      busy           = (state_ff != ptsu_pkg::ST_IDLE);
   end

endmodule

// File: hdl/ptsu_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Periodic task scheduler datapath
// Slot table, scan index, tick register, pending due item and result register.
// ---------------------------------------------------------------------------
module ptsu_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  ptsu_pkg::cmd_type             cmd,
   output ptsu_pkg::stat_type            stat,
   input  logic [ptsu_pkg::TAG_W-1:0]    req_task_tag,
   input  logic [ptsu_pkg::WORD_W-1:0]   req_task_argument,
   input  logic [ptsu_pkg::WORD_W-1:0]   req_period,
   input  logic                          csr_wr_en,
   input  logic [ptsu_pkg::WORD_W-1:0]   csr_wr_data,
   output logic                          rsp_valid,
   output logic [ptsu_pkg::STATUS_W-1:0] rsp_status,
   output logic [ptsu_pkg::SLOT_W-1:0]   rsp_slot,
   output logic [ptsu_pkg::TAG_W-1:0]    rsp_due_tag,
   output logic [ptsu_pkg::WORD_W-1:0]   rsp_due_argument,
   output logic                          rsp_last
);

   localparam logic [ptsu_pkg::SLOT_IDX_W-1:0] LAST_IDX =
      ptsu_pkg::SLOT_IDX_W'(ptsu_pkg::SLOTS - 1);

   // slot table
   logic [ptsu_pkg::TAG_W-1:0]  tag_mem     [ptsu_pkg::SLOTS];
   logic [ptsu_pkg::WORD_W-1:0] arg_mem     [ptsu_pkg::SLOTS];
   logic [ptsu_pkg::WORD_W-1:0] per_mem     [ptsu_pkg::SLOTS];
   logic [ptsu_pkg::WORD_W-1:0] elapsed_mem [ptsu_pkg::SLOTS];
   logic [ptsu_pkg::SLOTS-1:0]  occ_ff;
   logic [ptsu_pkg::SLOTS-1:0]  occ_in;

   logic [ptsu_pkg::TAG_W-1:0]  rd_tag_ff;
   logic [ptsu_pkg::WORD_W-1:0] rd_arg_ff;
   logic [ptsu_pkg::WORD_W-1:0] rd_per_ff;
   logic [ptsu_pkg::WORD_W-1:0] rd_elapsed_ff;

   logic [ptsu_pkg::SLOT_IDX_W-1:0] idx_ff;
   logic [ptsu_pkg::SLOT_IDX_W-1:0] idx_in;

   logic [ptsu_pkg::TAG_W-1:0]  tag_ff;
   logic [ptsu_pkg::WORD_W-1:0] arg_ff;
   logic [ptsu_pkg::WORD_W-1:0] per_ff;
   logic [ptsu_pkg::WORD_W-1:0] tick_ff;

   logic                            pend_valid_ff;
   logic                            pend_valid_in;
   logic [ptsu_pkg::SLOT_IDX_W-1:0] pend_slot_ff;
   logic [ptsu_pkg::TAG_W-1:0]      pend_tag_ff;
   logic [ptsu_pkg::WORD_W-1:0]     pend_arg_ff;

   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [ptsu_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [ptsu_pkg::STATUS_W-1:0] rsp_status_in;
   logic [ptsu_pkg::SLOT_W-1:0]   rsp_slot_ff;
   logic [ptsu_pkg::SLOT_W-1:0]   rsp_slot_in;
   logic [ptsu_pkg::TAG_W-1:0]    rsp_tag_ff;
   logic [ptsu_pkg::TAG_W-1:0]    rsp_tag_in;
   logic [ptsu_pkg::WORD_W-1:0]   rsp_arg_ff;
   logic [ptsu_pkg::WORD_W-1:0]   rsp_arg_in;
   logic                          rsp_last_ff;
   logic                          rsp_last_in;

   logic [ptsu_pkg::SLOT_IDX_W-1:0] free_idx;
   logic                            free_found;
   logic                            add_ok;
   logic [ptsu_pkg::WORD_W:0]       tick_sum;
   logic [ptsu_pkg::WORD_W-1:0]     tick_sat;
   logic [ptsu_pkg::WORD_W-1:0]     run_diff;
   logic                            slot_due;
   logic                            cur_occ;

   // lowest free slot
   always_comb begin
      free_idx   = '0;
      free_found = 1'b0;
      for (int i = ptsu_pkg::SLOTS - 1; i >= 0; i--) begin
         if (!occ_ff[i]) begin
            free_idx   = ptsu_pkg::SLOT_IDX_W'(i);
            free_found = 1'b1;
         end
      end
   end

   assign add_ok   = free_found && (tag_ff != '0) && (per_ff != '0);
   assign cur_occ  = occ_ff[idx_ff];
   assign tick_sum = {1'b0, rd_elapsed_ff} + {1'b0, tick_ff};
   assign tick_sat = tick_sum[ptsu_pkg::WORD_W] ? '1 : tick_sum[ptsu_pkg::WORD_W-1:0];
   assign run_diff = rd_elapsed_ff - rd_per_ff;
   assign slot_due = cur_occ && (rd_elapsed_ff >= rd_per_ff);
   assign stat.scan_last = (idx_ff == LAST_IDX);

   // scan index; read port addressed one step ahead
   always_comb begin
      idx_in = idx_ff;
      if (cmd.capture) begin
         idx_in = '0;
      end else if ((cmd.tick_step || cmd.run_step) && (idx_ff != LAST_IDX)) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_comb begin
      occ_in = occ_ff;
      if (cmd.add_step && add_ok) begin
         occ_in[free_idx] = 1'b1;
      end
   end

   always_comb begin
      pend_valid_in = pend_valid_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_arg_in    = rsp_arg_ff;
      rsp_last_in   = rsp_last_ff;
      priority if (cmd.capture) begin
         pend_valid_in = 1'b0;
      end else if (cmd.add_step) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = add_ok ? ptsu_pkg::STATUS_ADDED : ptsu_pkg::STATUS_REJECTED;
         rsp_slot_in   = add_ok ? ptsu_pkg::slot_field(free_idx) : '0;
         rsp_tag_in    = '0;
         rsp_arg_in    = '0;
         rsp_last_in   = 1'b1;
      end else if (cmd.run_step) begin
         if (slot_due) begin
            pend_valid_in = 1'b1;
            if (pend_valid_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ptsu_pkg::STATUS_DUE;
               rsp_slot_in   = ptsu_pkg::slot_field(pend_slot_ff);
               rsp_tag_in    = pend_tag_ff;
               rsp_arg_in    = pend_arg_ff;
               rsp_last_in   = 1'b0;
            end
         end
      end else if (cmd.flush_step) begin
         pend_valid_in = 1'b0;
         rsp_valid_in  = 1'b1;
         rsp_last_in   = 1'b1;
         if (pend_valid_ff) begin
            rsp_status_in = ptsu_pkg::STATUS_DUE;
            rsp_slot_in   = ptsu_pkg::slot_field(pend_slot_ff);
            rsp_tag_in    = pend_tag_ff;
            rsp_arg_in    = pend_arg_ff;
         end else begin
            rsp_status_in = ptsu_pkg::STATUS_NONE_DUE;
            rsp_slot_in   = '0;
            rsp_tag_in    = '0;
            rsp_arg_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff        <= '0;
         idx_ff        <= '0;
         tick_ff       <= ptsu_pkg::WORD_W'(1);
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         occ_ff        <= occ_in;
         idx_ff        <= idx_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            tick_ff <= (csr_wr_data == '0) ? ptsu_pkg::WORD_W'(1) : csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         tag_ff <= req_task_tag;
         arg_ff <= req_task_argument;
         per_ff <= req_period;
      end
      if (cmd.run_step && slot_due) begin
         pend_slot_ff <= idx_ff;
         pend_tag_ff  <= rd_tag_ff;
         pend_arg_ff  <= rd_arg_ff;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_arg_ff    <= rsp_arg_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // table write port
   always_ff @(posedge clock) begin
      if (cmd.add_step && add_ok) begin
         tag_mem[free_idx]     <= tag_ff;
         arg_mem[free_idx]     <= arg_ff;
         per_mem[free_idx]     <= per_ff;
         elapsed_mem[free_idx] <= '0;
      end else if (cmd.tick_step && cur_occ) begin
         elapsed_mem[idx_ff] <= tick_sat;
      end else if (cmd.run_step && slot_due) begin
         elapsed_mem[idx_ff] <= run_diff;
      end
   end

   // table read port
   always_ff @(posedge clock) begin
      rd_tag_ff     <= tag_mem[idx_in];
      rd_arg_ff     <= arg_mem[idx_in];
      rd_per_ff     <= per_mem[idx_in];
      rd_elapsed_ff <= elapsed_mem[idx_in];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_due_tag      = rsp_tag_ff;
   assign rsp_due_argument = rsp_arg_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

// File: tb/sv/tb_periodic_task_scheduler_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Periodic task scheduler unit testbench
// Drives add, tick and run-pending items through the start/busy port, and
// tracks a private copy of the slot table to predict every result. The
// predicted results are compared field by field with what the block strobes.
// The sender idles at random, and the tick amount is rewritten while the
// block is idle between phases.
// ---------------------------------------------------------------------------
module tb_periodic_task_scheduler_unit;
   import ptsu_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = SLOTS + 6;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [TAG_W-1:0]    tag;
      logic [WORD_W-1:0]   argument;
      logic                last;
   } sched_result_type;

   class task_table_checker;
      logic                occupied [SLOTS];
      logic [TAG_W-1:0]    tags     [SLOTS];
      logic [WORD_W-1:0]   args     [SLOTS];
      logic [WORD_W-1:0]   periods  [SLOTS];
      logic [WORD_W-1:0]   elapsed  [SLOTS];
      logic [WORD_W-1:0]   tick_amount;
      sched_result_type    pending_results[$];
      int                  errors;

      function new();
         foreach (occupied[i]) begin
            occupied[i] = 1'b0;
            tags[i]     = '0;
            args[i]     = '0;
            periods[i]  = '0;
            elapsed[i]  = '0;
         end
         tick_amount = 1;
         errors      = 0;
      endfunction

      function void write_tick_amount(logic [WORD_W-1:0] value);
         tick_amount = (value == '0) ? 1 : value;
      endfunction

      function void accept_item(logic [KIND_W-1:0] kind, logic [TAG_W-1:0] tag,
                                logic [WORD_W-1:0] arg, logic [WORD_W-1:0] per);
         int               free_slot;
         logic [WORD_W:0]  sum;
         sched_result_type r;
         sched_result_type due_list[$];
         case (kind)
            KIND_ADD: begin
               free_slot = -1;
               if (tag != '0 && per != '0) begin
                  for (int i = 0; i < SLOTS; i++)
                     if (!occupied[i] && free_slot < 0) free_slot = i;
               end
               if (free_slot < 0) begin
                  r = '{STATUS_REJECTED, SLOT_W'(0), TAG_W'(0), WORD_W'(0), 1'b1};
               end else begin
                  tags[free_slot]     = tag;
                  args[free_slot]     = arg;
                  periods[free_slot]  = per;
                  elapsed[free_slot]  = '0;
                  occupied[free_slot] = 1'b1;
                  r = '{STATUS_ADDED, SLOT_W'(free_slot), TAG_W'(0), WORD_W'(0), 1'b1};
               end
               pending_results.push_back(r);
            end
            KIND_TICK: begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (occupied[i]) begin
                     sum = {1'b0, elapsed[i]} + {1'b0, tick_amount};
                     elapsed[i] = sum[WORD_W] ? '1 : sum[WORD_W-1:0];
                  end
               end
            end
            KIND_RUN: begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (occupied[i] && elapsed[i] >= periods[i]) begin
                     elapsed[i] = elapsed[i] - periods[i];
                     r = '{STATUS_DUE, SLOT_W'(i), tags[i], args[i], 1'b0};
                     due_list.push_back(r);
                  end
               end
               if (due_list.size() == 0) begin
                  r = '{STATUS_NONE_DUE, SLOT_W'(0), TAG_W'(0), WORD_W'(0), 1'b1};
                  pending_results.push_back(r);
               end else begin
                  for (int i = 0; i < due_list.size(); i++) begin
                     r = due_list[i];
                     r.last = (i == due_list.size() - 1);
                     pending_results.push_back(r);
                  end
               end
            end
            default: ;
         endcase
      endfunction

      function void compare_field(string field_name, logic [WORD_W-1:0] want,
                                  logic [WORD_W-1:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field_name,
                     want, got);
         end
      endfunction

      function void check_result(sched_result_type got);
         sched_result_type want;
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
         end else begin
            want = pending_results.pop_front();
            compare_field("status", WORD_W'(want.status), WORD_W'(got.status));
            compare_field("slot", WORD_W'(want.slot), WORD_W'(got.slot));
            compare_field("due_tag", WORD_W'(want.tag), WORD_W'(got.tag));
            compare_field("due_argument", want.argument, got.argument);
            compare_field("last", WORD_W'(want.last), WORD_W'(got.last));
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [KIND_W-1:0]   req_kind;
   logic [TAG_W-1:0]    req_task_tag;
   logic [WORD_W-1:0]   req_task_argument;
   logic [WORD_W-1:0]   req_period;
   logic                csr_wr_en;
   logic [WORD_W-1:0]   csr_wr_data;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_slot;
   logic [TAG_W-1:0]    rsp_due_tag;
   logic [WORD_W-1:0]   rsp_due_argument;
   logic                rsp_last;

   task_table_checker table_chk;
   int                sender_idle_pct;

   periodic_task_scheduler_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_task_tag     (req_task_tag),
      .req_task_argument(req_task_argument),
      .req_period       (req_period),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_slot         (rsp_slot),
      .rsp_due_tag      (rsp_due_tag),
      .rsp_due_argument (rsp_due_argument),
      .rsp_last         (rsp_last)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            table_chk.accept_item(req_kind, req_task_tag, req_task_argument, req_period);
         if (rsp_valid)
            table_chk.check_result('{rsp_status, rsp_slot, rsp_due_tag,
                                     rsp_due_argument, rsp_last});
      end
   end

   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [TAG_W-1:0] tag,
                            input logic [WORD_W-1:0] arg, input logic [WORD_W-1:0] per);
      if ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct) @(posedge clock);
      end
      start             <= 1'b1;
      req_kind          <= kind;
      req_task_tag      <= tag;
      req_task_argument <= arg;
      req_period        <= per;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic drain_results(input int settle);
      start <= 1'b0;
      @(posedge clock);
      while (table_chk.pending_results.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_tick_amount(input logic [WORD_W-1:0] value);
      drain_results(SETTLE_CYCLES);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      table_chk.write_tick_amount(value);
   endtask

   task automatic send_random_items(input int count);
      int                sent;
      int                pick;
      logic [TAG_W-1:0]  tag;
      logic [WORD_W-1:0] per;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            tag = ($urandom_range(9) == 0) ? '0 : TAG_W'($urandom);
            per = ($urandom_range(9) == 0) ? '0 : $urandom;
            send_item(KIND_ADD, tag, $urandom, per);
            sent++;
         end else if (pick < 12) begin
            send_item(KIND_UNUSED, TAG_W'($urandom), $urandom, $urandom);
         end else if (pick < 55) begin
            send_item(KIND_TICK, TAG_W'($urandom), $urandom, $urandom);
            sent++;
         end else begin
            send_item(KIND_RUN, TAG_W'($urandom), $urandom, $urandom);
            sent++;
         end
         if ($urandom_range(99) < 2) drain_results(0);
      end
   endtask

   initial begin
      table_chk         = new();
      sender_idle_pct   = 12;
      clock             = 1'b0;
      reset             <= 1'b1;
      start             <= 1'b0;
      req_kind          <= KIND_ADD;
      req_task_tag      <= '0;
      req_task_argument <= '0;
      req_period        <= '0;
      csr_wr_en         <= 1'b0;
      csr_wr_data       <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(KIND_RUN, '0, '0, '0);
      send_item(KIND_ADD, '0, 32'h1234_5678, 32'd5);
      send_item(KIND_ADD, 16'd5, 32'h0000_0001, '0);
      send_item(KIND_UNUSED, 16'hFFFF, '1, '1);
      send_item(KIND_ADD, 16'hFFFF, '1, '1);
      send_item(KIND_ADD, 16'h0001, '0, 32'h8000_0000);
      send_item(KIND_TICK, '0, '0, '0);
      send_item(KIND_RUN, '0, '0, '0);

      // saturate elapsed time, then drain both slots
      write_tick_amount('1);
      send_item(KIND_TICK, '0, '0, '0);
      send_item(KIND_TICK, '0, '0, '0);
      send_item(KIND_RUN, '0, '0, '0);
      send_item(KIND_RUN, '0, '0, '0);

      // zero write falls back to one
      write_tick_amount('0);
      send_item(KIND_TICK, '0, '0, '0);
      send_item(KIND_RUN, '0, '0, '0);

      for (int i = 2; i < SLOTS; i++)
         send_item(KIND_ADD, TAG_W'($urandom_range(1, 16'hFFFF)), $urandom,
                   $urandom_range(4, 40));
      send_item(KIND_ADD, 16'h00A5, $urandom, 32'd7);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct = 12;
               write_tick_amount(1);
            end
            1: begin
               sender_idle_pct = 75;
               write_tick_amount($urandom_range(2, 5));
            end
            default: begin
               sender_idle_pct = 0;
               write_tick_amount($urandom_range(1, 3));
            end
         endcase
         send_random_items(150);
      end

      drain_results(SETTLE_CYCLES);
      if (table_chk.errors == 0 && table_chk.pending_results.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
